/* hw/rtl/pal_pkg.sv */
// ----------------------------------------------------------------------------
// pal_pkg
// Shared constants, types and word helpers for the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

   // Store geometry
   localparam int CAPACITY      = 64;
   localparam int ELEMENT_WIDTH = 32;
   localparam int IDX_W         = $clog2(CAPACITY);
   localparam int CNT_W         = $clog2(CAPACITY + 1);

   // Fixed field widths
   localparam int KIND_W = 3;
   localparam int POS_W  = 7;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;

   // Width for position/length compares
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   // First-match search: groups of eight cells
   localparam int GROUP      = 8;
   localparam int GIDX_W     = 3;
   localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;
   localparam int NG_W       = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

   typedef logic [ELEMENT_WIDTH-1:0] word_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 3'd0,
      KIND_DELETE = 3'd1,
      KIND_GET    = 3'd2,
      KIND_LOCATE = 3'd3,
      KIND_CLEAR  = 3'd4
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_POS   = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESOLVE
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE
   } cell_op_type;

   // Broadcast to every cell of the row
   typedef struct packed {
      cell_op_type             op;
      logic [IDX_W-1:0]        idx;
      word_type                word;
      logic [CNT_W-1:0]        count;
   } cell_ctrl_type;

   // 32-bit input value, sign-extended, kept in ELEMENT_WIDTH bits
   function automatic word_type to_word(input logic [VAL_W-1:0] v);
      logic [63:0] ext;
      ext = {{32{v[VAL_W-1]}}, v};
      return ext[ELEMENT_WIDTH-1:0];
   endfunction

   // Stored word, sign-extended from ELEMENT_WIDTH bits, cut to 32 bits
   function automatic logic [VAL_W-1:0] word_out(input word_type w);
      logic [63:0] ext;
      ext = {{(64 - ELEMENT_WIDTH){w[ELEMENT_WIDTH-1]}}, w};
      return ext[VAL_W-1:0];
   endfunction

endpackage

/* hw/rtl/pal_req_if.sv */
// ----------------------------------------------------------------------------
// pal_req_if
// Command channel: valid/ready handshake with kind, position and value.
// ----------------------------------------------------------------------------
interface pal_req_if import pal_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic [POS_W-1:0]         position;
   logic signed [VAL_W-1:0]  value;

   modport source (output valid, kind, position, value, input ready);
   modport sink   (input valid, kind, position, value, output ready);
endinterface

/* hw/rtl/pal_rsp_if.sv */
// ----------------------------------------------------------------------------
// pal_rsp_if
// Result channel: valid/ready handshake with status, value, position, length.
// ----------------------------------------------------------------------------
interface pal_rsp_if import pal_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic signed [VAL_W-1:0]  read_value;
   logic [POS_W-1:0]         found_position;
   logic [POS_W-1:0]         list_length;

   modport source (output valid, status, read_value, found_position, list_length,
                   input ready);
   modport sink   (input valid, status, read_value, found_position, list_length,
                   output ready);
endinterface

/* hw/rtl/pal_cell.sv */
// ----------------------------------------------------------------------------
// pal_cell
// One list entry: shifts up or down with its neighbors, compares and selects.
// ----------------------------------------------------------------------------
module pal_cell import pal_pkg::*; (
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [IDX_W-1:0]  index,
   input  word_type          lower_word,
   input  word_type          upper_word,
   output word_type          word,
   output logic              match,
   output word_type          pick
);

   word_type word_ff;
   word_type word_in;
   logic     at_idx;
   logic     above_idx;
   logic     in_list;

   // Position relative to the command target
   assign at_idx    = (index == ctrl.idx);
   assign above_idx = (index > ctrl.idx);
   assign in_list   = ({1'b0, index} < (IDX_W + 1)'(ctrl.count));

   // Next entry value
   always_comb begin
      word_in = word_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (above_idx) word_in = lower_word;
            else if (at_idx) word_in = ctrl.word;
         end
         CELL_DELETE: begin
            if (at_idx || above_idx) word_in = upper_word;
         end
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   // Compare and select on the current contents
   assign word  = word_ff;
   assign match = in_list && (word_ff == ctrl.word);
   assign pick  = at_idx ? word_ff : '0;

endmodule

/* hw/rtl/positional_array_list_core.sv */
// ----------------------------------------------------------------------------
// positional_array_list_core
// Ordered list of signed words kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Sequence: accept in idle, cell update/compare in exec, then first-match
//   resolve into the result register, which waits while the result port stalls.
// A new command is taken only once the previous one has resolved, set by the
//   accept/exec/resolve sequence; the output register frees the input side.
// Reset: clears the sequencer, the length and the result valid; the cell
//   contents stay undefined and are only read below the length.
module positional_array_list_core import pal_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   pal_req_if.sink       req_chan,
   pal_rsp_if.source     rsp_chan
);

   state_type                state_ff, state_in;

   // Latched command
   kind_type                 kind_ff;
   logic [POS_W-1:0]         pos_ff;
   word_type                 word_ff;
   logic [CNT_W-1:0]         count_ff, count_in;

   // Exec-stage results
   status_type               status_ff, status_in;
   logic [VAL_W-1:0]         read_ff, read_in;
   logic                     locate_ff, locate_in;
   logic [CAPACITY-1:0]      match_ff;

   // Result register
   logic                     rsp_valid_ff;
   status_type               rsp_status_ff;
   logic [VAL_W-1:0]         rsp_read_ff;
   logic [POS_W-1:0]         rsp_found_ff;
   logic [POS_W-1:0]         rsp_length_ff;

   logic                     req_xfer;
   logic                     exec_en;
   logic                     resolve_fire;

   cell_ctrl_type            ctrl;
   word_type                 cell_word [CAPACITY];
   logic [CAPACITY-1:0]      cell_match;
   word_type                 cell_pick [CAPACITY];
   word_type                 pick_or;

   logic [CMP_W-1:0]         pos_ext;
   logic [CMP_W-1:0]         cnt_ext;
   logic [CMP_W-1:0]         pos_m1;

   // ---------------------------------------------------------------- FSM
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_xfer) state_in = ST_EXEC;
         ST_EXEC:    state_in = ST_RESOLVE;
         ST_RESOLVE: if (!rsp_valid_ff || rsp_chan.ready) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      exec_en        = (state_ff == ST_EXEC);
      resolve_fire   = (state_ff == ST_RESOLVE) && (!rsp_valid_ff || rsp_chan.ready);
   end

   assign req_xfer = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Command latch
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         kind_ff <= kind_type'(req_chan.kind);
         pos_ff  <= req_chan.position;
         word_ff <= to_word(req_chan.value);
      end
   end

   // ---------------------------------------------------------------- cell row
   assign pos_ext = CMP_W'(pos_ff);
   assign cnt_ext = CMP_W'(count_ff);
   assign pos_m1  = pos_ext - CMP_W'(1);

   // Decide the command and drive the row
   always_comb begin
      ctrl.op    = CELL_HOLD;
      ctrl.idx   = pos_m1[IDX_W-1:0];
      ctrl.word  = word_ff;
      ctrl.count = count_ff;
      count_in   = count_ff;
      status_in  = STATUS_OK;
      read_in    = '0;
      locate_in  = 1'b0;
      if (exec_en) begin
         unique case (kind_ff)
            KIND_INSERT: begin
               if (pos_ff == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
                  status_in = STATUS_BAD_POS;
               end else if (cnt_ext >= CMP_W'(CAPACITY)) begin
                  status_in = STATUS_FULL;
               end else begin
                  ctrl.op  = CELL_INSERT;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            KIND_DELETE: begin
               if (pos_ff == '0 || pos_ext > cnt_ext) begin
                  status_in = STATUS_BAD_POS;
               end else begin
                  ctrl.op  = CELL_DELETE;
                  read_in  = word_out(pick_or);
                  count_in = count_ff - CNT_W'(1);
               end
            end
            KIND_GET: begin
               if (pos_ff == '0 || pos_ext > cnt_ext) begin
                  status_in = STATUS_BAD_POS;
               end else begin
                  read_in = word_out(pick_or);
               end
            end
            KIND_LOCATE: locate_in = 1'b1;
            KIND_CLEAR:  count_in  = '0;
            default:     status_in = STATUS_OK;
         endcase
      end
   end

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      word_type lower_w;
      word_type upper_w;
      if (k == 0) begin : g_first
         assign lower_w = cell_word[k];
      end else begin : g_low
         assign lower_w = cell_word[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
         assign upper_w = cell_word[k];
      end else begin : g_up
         assign upper_w = cell_word[k+1];
      end
      pal_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .index      (IDX_W'(k)),
         .lower_word (lower_w),
         .upper_word (upper_w),
         .word       (cell_word[k]),
         .match      (cell_match[k]),
         .pick       (cell_pick[k])
      );
   end

   // Selected entry: only one cell drives a nonzero pick
   always_comb begin
      pick_or = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         pick_or = pick_or | cell_pick[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_en) begin
         status_ff <= status_in;
         read_ff   <= read_in;
         locate_ff <= locate_in;
         match_ff  <= cell_match;
      end
   end

   // ---------------------------------------------------------------- resolve
   logic [NUM_GROUPS*GROUP-1:0] hits;
   logic [NUM_GROUPS-1:0]       grp_any;
   logic [GIDX_W-1:0]           grp_off [NUM_GROUPS];
   logic [NG_W-1:0]             first_g;
   logic [NG_W+GIDX_W:0]        found_sum;
   logic                        any_hit;

   // Two-level first-match search over the registered match bits
   always_comb begin
      hits = '0;
      hits[CAPACITY-1:0] = match_ff;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_any[g] = |hits[g*GROUP +: GROUP];
         grp_off[g] = '0;
         for (int b = GROUP - 1; b >= 0; b--) begin
            if (hits[g*GROUP + b]) grp_off[g] = GIDX_W'(b);
         end
      end
      first_g = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_any[g]) first_g = NG_W'(g);
      end
      any_hit   = |match_ff;
      found_sum = (NG_W + GIDX_W + 1)'({first_g, grp_off[first_g]}) +
                  (NG_W + GIDX_W + 1)'(1);
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (resolve_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (resolve_fire) begin
         rsp_read_ff   <= read_ff;
         rsp_length_ff <= POS_W'(count_ff);
         if (locate_ff && any_hit) begin
            rsp_status_ff <= STATUS_OK;
            rsp_found_ff  <= POS_W'(found_sum);
         end else if (locate_ff) begin
            rsp_status_ff <= STATUS_NOT_FOUND;
            rsp_found_ff  <= '0;
         end else begin
            rsp_status_ff <= status_ff;
            rsp_found_ff  <= '0;
         end
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.read_value     = rsp_read_ff;
   assign rsp_chan.found_position = rsp_found_ff;
   assign rsp_chan.list_length    = rsp_length_ff;

   // ---------------------------------------------------------------- checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (CMP_W'(count_ff) <= CMP_W'(CAPACITY)))
      else $error("list length exceeds capacity");

   a_count_only_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_EXEC) |=> $stable(count_ff))
      else $error("list length changed outside exec");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      (exec_en && ctrl.op == CELL_DELETE) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("delete did not shrink the list");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff != '0) |-> (rsp_status_ff == STATUS_OK))
      else $error("found position with non-ok status");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_EXEC))
      else $error("accepted command not executed");

endmodule
